FILE: hdl/kptm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_pkg
// shared types and constants of the kernel page table mapper
// ----------------------------------------------------------------------------
package kptm_pkg;

    // table pool size in frames, each frame holds one 512-entry table
    localparam int POOL_FRAMES = 64;
    localparam int SLOT_W      = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
    localparam int USED_W      = $clog2(POOL_FRAMES + 1);
    localparam int IDX_W       = 9;
    localparam int TBL_AW      = SLOT_W + IDX_W;
    localparam int TBL_DEPTH   = POOL_FRAMES * (1 << IDX_W);
    localparam int PDPT_DEPTH  = 1 << IDX_W;

    // entries only ever hold address bits 55..12 and the low flag bits
    localparam int ENT_W  = 56;
    localparam int FN_W   = 44;
    localparam int VA_W   = 64;
    localparam int PA_W   = 56;
    localparam int TOP_LO = 39;

    localparam logic [FN_W-1:0] POOL_BASE_RST = FN_W'(256);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFRAME = 3'd1,
        ST_OUTSIDE = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_REWRITE = 3'd4
    } t_status;

    // what one intermediate entry means for the walk
    typedef enum logic [2:0] {
        ACT_CORRUPT,
        ACT_EMPTY,
        ACT_NOFRAME,
        ACT_ALLOC,
        ACT_DESCEND
    } t_act;

    typedef struct packed {
        t_act              act;
        logic [SLOT_W-1:0] slot;
    } t_desc;

endpackage

FILE: hdl/kptm_entry_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kptm_entry_chk
// decodes one intermediate table entry: descend, allocate, report empty or fail
// ----------------------------------------------------------------------------
module kptm_entry_chk (
    input  logic [kptm_pkg::ENT_W-1:0]  i_entry,
    input  logic                        i_set,
    input  logic [kptm_pkg::FN_W-1:0]   i_base,
    input  logic [kptm_pkg::USED_W-1:0] i_used,
    output kptm_pkg::t_desc             o_desc,
    output logic [kptm_pkg::ENT_W-1:0]  o_new_entry
);
    import kptm_pkg::*;

    logic [FN_W-1:0] fn;
    logic [FN_W-1:0] fn_ofs;
    logic [FN_W-1:0] fn_new;
    logic            in_pool;
    logic            pool_full;

    assign fn        = i_entry[ENT_W-1:12];
    assign fn_ofs    = fn - i_base;
    assign in_pool   = fn_ofs < {{(FN_W-USED_W){1'b0}}, i_used};
    assign pool_full = i_used >= USED_W'(POOL_FRAMES);

    // next free frame, entered present and writable
    assign fn_new      = i_base + {{(FN_W-SLOT_W){1'b0}}, i_used[SLOT_W-1:0]};
    assign o_new_entry = {fn_new, 12'h003};

    always_comb begin
        o_desc.slot = i_used[SLOT_W-1:0];
        if (!i_entry[0]) begin
            if (i_entry != '0) begin
                o_desc.act = ACT_CORRUPT;
            end else if (!i_set) begin
                o_desc.act = ACT_EMPTY;
            end else if (pool_full) begin
                o_desc.act = ACT_NOFRAME;
            end else begin
                o_desc.act = ACT_ALLOC;
            end
        end else if (in_pool) begin
            o_desc.act  = ACT_DESCEND;
            o_desc.slot = fn_ofs[SLOT_W-1:0];
        end else begin
            o_desc.act = ACT_CORRUPT;
        end
    end

endmodule

FILE: hdl/kernel_page_table_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_page_table_mapper_core
// three-level page table walker for the top 512 GiB, with a frame pool
// ----------------------------------------------------------------------------
//  channel   dir  signals                         contents
//  s_axis    in   tvalid tready tuser tdata[119:0] tuser: func
//                                                  tdata: vaddr, paddr
//  m_axis    out  tvalid tready tdata[63:0]        tdata: status, frame_addr
//  cfg       in   i_cfg_we i_cfg_wdata[43:0]       pool_base_frame
//
//  one request at a time; a plain walk steps through accept, pdpt read,
//  table read, leaf read and result; each level waits on the registered
//  memory read
//  every table taken from the pool adds a clearing pass: its 512 entries
//  are cleared one per cycle through the table write port, then re-read
//  after reset all pdpt entries are cleared, no request taken
//  a result waiting on m_axis_tready does not block the next accept; the
//  walk then holds in its final state until the output register frees
// ----------------------------------------------------------------------------
module kernel_page_table_mapper_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request: tuser = func
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic                       s_axis_tuser,
    // request: [63:0] vaddr, [119:64] paddr
    input  logic [119:0]               s_axis_tdata,
    // result: [2:0] status, [58:3] frame_addr, [63:59] zero
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,
    // pool base frame register
    input  logic                       i_cfg_we,
    input  logic [kptm_pkg::FN_W-1:0]  i_cfg_wdata
);
    import kptm_pkg::*;

    // one-hot walk sequencer
    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,  // pdpt clearing pass
        S_IDLE  = 8'b0000_0010,
        S_WALK1 = 8'b0000_0100,  // pdpt entry on read port
        S_WALK2 = 8'b0000_1000,  // page directory entry on read port
        S_CLEAR = 8'b0001_0000,  // clearing a freshly taken frame
        S_ISSUE = 8'b0010_0000,  // read the entry of the fresh table
        S_WALK3 = 8'b0100_0000,  // leaf entry on read port
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_sweep, n_sweep;
    logic [USED_W-1:0]    r_used, n_used;
    logic [FN_W-1:0]      r_base;
    logic                 r_set;
    logic [PA_W-1:0]      r_paddr;
    logic [IDX_W-1:0]     r_pdpt_idx, r_pd_idx, r_pt_idx;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic                 r_level, n_level;   // fresh table is a page table
    t_status              r_status, n_status;
    logic [PA_W-1:0]      r_result, n_result;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [PA_W-1:0]      r_out_addr;

    // memories
    logic [ENT_W-1:0]     pdpt_mem [PDPT_DEPTH];
    logic [ENT_W-1:0]     tbl_mem  [TBL_DEPTH];
    logic [ENT_W-1:0]     r_pdpt_rd, r_tbl_rd;
    logic                 pdpt_we, tbl_we;
    logic [IDX_W-1:0]     pdpt_waddr, pdpt_raddr;
    logic [ENT_W-1:0]     pdpt_wdata, tbl_wdata;
    logic [TBL_AW-1:0]    tbl_waddr, tbl_raddr;

    logic                 in_take;
    logic                 out_free;
    logic                 paddr_nz;
    logic [ENT_W-1:0]     chk_entry;
    logic [ENT_W-1:0]     new_entry;
    t_desc                desc;
    logic [VA_W-1:0]      in_vaddr;
    logic [PA_W-1:0]      in_paddr;

    assign in_vaddr = s_axis_tdata[VA_W-1:0];
    assign in_paddr = s_axis_tdata[VA_W+PA_W-1:VA_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign paddr_nz      = (r_paddr != '0);

    // shared entry decoder, fed by whichever level is on its read port
    assign chk_entry = (r_state == S_WALK1) ? r_pdpt_rd : r_tbl_rd;

    kptm_entry_chk u_chk (
        .i_entry     (chk_entry),
        .i_set       (r_set),
        .i_base      (r_base),
        .i_used      (r_used),
        .o_desc      (desc),
        .o_new_entry (new_entry)
    );

    // pdpt memory: read every cycle at the incoming request's index
    assign pdpt_raddr = in_vaddr[38:30];

    always_ff @(posedge i_clk) begin
        if (pdpt_we) begin
            pdpt_mem[pdpt_waddr] <= pdpt_wdata;
        end
        r_pdpt_rd <= pdpt_mem[pdpt_raddr];
    end

    // table memory: one write and one read port. every read comes after the
    // write it depends on has landed, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_rd <= tbl_mem[tbl_raddr];
    end

    // sequencer and memory control
    always_comb begin
        n_state    = r_state;
        n_sweep    = r_sweep;
        n_used     = r_used;
        n_slot     = r_slot;
        n_level    = r_level;
        n_status   = r_status;
        n_result   = r_result;
        pdpt_we    = 1'b0;
        pdpt_waddr = r_pdpt_idx;
        pdpt_wdata = new_entry;
        tbl_we     = 1'b0;
        tbl_waddr  = {r_slot, r_pt_idx};
        tbl_wdata  = '0;
        tbl_raddr  = {r_slot, r_pd_idx};

        unique case (r_state)
            S_INIT: begin
                pdpt_we    = 1'b1;
                pdpt_waddr = r_sweep;
                pdpt_wdata = '0;
                n_sweep    = r_sweep + 1'b1;
                if (r_sweep == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    n_status = ST_OK;
                    n_result = '0;
                    if (in_vaddr[VA_W-1:TOP_LO] != '1) begin
                        n_status = ST_OUTSIDE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_WALK1;
                    end
                end
            end
            S_WALK1, S_WALK2: begin
                n_level = (r_state == S_WALK2);
                case (desc.act)
                    ACT_CORRUPT: begin
                        n_status = ST_CORRUPT;
                        n_state  = S_DONE;
                    end
                    ACT_EMPTY: begin
                        n_state = S_DONE;
                    end
                    ACT_NOFRAME: begin
                        // page is already unmapped when paddr is zero
                        n_status = paddr_nz ? ST_NOFRAME : ST_OK;
                        n_state  = S_DONE;
                    end
                    ACT_ALLOC: begin
                        if (r_state == S_WALK1) begin
                            pdpt_we = 1'b1;
                        end else begin
                            tbl_we    = 1'b1;
                            tbl_waddr = {r_slot, r_pd_idx};
                            tbl_wdata = new_entry;
                        end
                        n_used  = r_used + 1'b1;
                        n_slot  = desc.slot;
                        n_sweep = '0;
                        n_state = S_CLEAR;
                    end
                    default: begin
                        // present entry inside the pool: read next level now
                        n_slot    = desc.slot;
                        tbl_raddr = {desc.slot,
                                     (r_state == S_WALK1) ? r_pd_idx : r_pt_idx};
                        n_state   = (r_state == S_WALK1) ? S_WALK2 : S_WALK3;
                    end
                endcase
            end
            S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = {r_slot, r_sweep};
                tbl_wdata = '0;
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == '1) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                tbl_raddr = {r_slot, r_level ? r_pt_idx : r_pd_idx};
                n_state   = r_level ? S_WALK3 : S_WALK2;
            end
            S_WALK3: begin
                tbl_waddr = {r_slot, r_pt_idx};
                if (!r_tbl_rd[0]) begin
                    if (r_tbl_rd != '0) begin
                        n_status = ST_CORRUPT;
                    end else if (r_set && paddr_nz) begin
                        tbl_we    = 1'b1;
                        tbl_wdata = r_paddr | PA_W'(3);
                    end
                end else if (r_set) begin
                    if (paddr_nz) begin
                        n_status = ST_REWRITE;
                    end else begin
                        tbl_we    = 1'b1;
                        tbl_wdata = '0;
                    end
                end else begin
                    n_result = {r_tbl_rd[ENT_W-1:12], 12'h000};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_used      <= '0;
            r_base      <= POOL_BASE_RST;
            r_out_valid <= 1'b0;
            r_level     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_used  <= n_used;
            r_level <= n_level;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_status <= n_status;
        r_result <= n_result;
        if (in_take) begin
            r_set      <= !s_axis_tuser;
            r_paddr    <= in_paddr;
            r_pdpt_idx <= in_vaddr[38:30];
            r_pd_idx   <= in_vaddr[29:21];
            r_pt_idx   <= in_vaddr[20:12];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_addr   <= (r_status == ST_OK) ? r_result : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_addr, r_out_status};

    // checks
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(POOL_FRAMES))
        else $error("frame pool overrun");

    a_clear_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> ({1'b0, r_slot} < {1'b0, r_used}))
        else $error("clearing a frame that was not taken");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result without a finished walk");

    a_alloc_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && $past(r_state != S_CLEAR)) |-> r_used == $past(r_used) + 1'b1)
        else $error("fresh frame not counted");

endmodule
